// ----- rtl/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the RPN stack ALU: command and status
// codes, the microcode control word and the sequencer condition flags.
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam int DATA_W            = 32;
   localparam int RSA_STACK_DEPTH   = 512;
   localparam int DEPTH_FIELD_W     = 10;
   localparam int CMD_W             = 3;
   localparam int UPC_W             = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 3'd0,
      CMD_POP  = 3'd1,
      CMD_ADD  = 3'd2,
      CMD_SUB  = 3'd3,
      CMD_MUL  = 3'd4,
      CMD_DIV  = 3'd5
   } rsa_cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_FEW  = 2'd2,
      ST_DIVZ = 2'd3
   } rsa_status_type;

   // jump conditions
   typedef enum logic [2:0] {
      JC_NONE    = 3'd0,
      JC_ALWAYS  = 3'd1,
      JC_FULL    = 3'd2,
      JC_LT1     = 3'd3,
      JC_LT2     = 3'd4,
      JC_BZ      = 3'd5,
      JC_DIV     = 3'd6,
      JC_DIVBUSY = 3'd7
   } rsa_jump_type;

   // stack read address select
   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_TOP  = 2'd1,
      RD_NEXT = 2'd2
   } rsa_rd_type;

   // operand / result register loads
   typedef enum logic [2:0] {
      LD_NONE = 3'd0,
      LD_A    = 3'd1,
      LD_B    = 3'd2,
      LD_ALU  = 3'd3,
      LD_DIV  = 3'd4
   } rsa_ld_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2,
      CNT_DEC2 = 2'd3
   } rsa_cnt_type;

   typedef enum logic [1:0] {
      WR_NONE = 2'd0,
      WR_PUSH = 2'd1,
      WR_RES  = 2'd2
   } rsa_wr_type;

   typedef struct packed {
      rsa_jump_type   jc;
      logic [UPC_W-1:0] target;
      rsa_rd_type     rd;
      rsa_ld_type     ld;
      rsa_cnt_type    cnt_op;
      rsa_wr_type     wr;
      logic           st_set;
      rsa_status_type st_code;
      logic           div_start;
      logic           done;
   } rsa_ctrl_type;

   typedef struct packed {
      logic full;
      logic lt1;
      logic lt2;
      logic bz;
      logic is_div;
      logic div_busy;
      logic out_free;
   } rsa_cond_type;

endpackage

// ----- rtl/rsa_div.sv -----
// ----------------------------------------------------------------------------
// rsa_div
// Iterative signed divider, one restoring step per cycle, quotient
// truncated toward zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module rsa_div
   import rsa_pkg::*;
#(
   parameter int DW = DATA_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);

   localparam int CNTW = $clog2(DW + 1);

   typedef enum logic {DV_IDLE, DV_RUN} dv_state_type;

   dv_state_type    state_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [DW-1:0]   rem_ff;
   logic [DW-1:0]   quo_ff;
   logic [DW-1:0]   dvs_ff;
   logic            neg_ff;

   logic [DW:0]     shifted;
   logic [DW:0]     diff;
   logic [DW-1:0]   mag_a;
   logic [DW-1:0]   mag_b;

   assign mag_a   = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
   assign mag_b   = divisor[DW-1]  ? (~divisor + 1'b1)  : divisor;
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  state_ff <= DV_RUN;
                  cnt_ff   <= CNTW'(DW);
                  rem_ff   <= '0;
                  quo_ff   <= mag_a;
                  dvs_ff   <= mag_b;
                  neg_ff   <= dividend[DW-1] ^ divisor[DW-1];
               end
            end
            DV_RUN: begin
               // restoring step: keep the difference when no borrow
               if (!diff[DW]) begin
                  rem_ff <= diff[DW-1:0];
                  quo_ff <= {quo_ff[DW-2:0], 1'b1};
               end else begin
                  rem_ff <= shifted[DW-1:0];
                  quo_ff <= {quo_ff[DW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNTW'(1)) begin
                  state_ff <= DV_IDLE;
               end
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign busy     = (state_ff == DV_RUN);
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// ----- rtl/rsa_seq.sv -----
// ----------------------------------------------------------------------------
// rsa_seq
// Microcode sequencer: step counter, dispatch on command and the control
// store that drives the stack datapath.
// ----------------------------------------------------------------------------
module rsa_seq
   import rsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] start_cmd,
   input  rsa_cond_type     cond,
   output rsa_ctrl_type     ctrl,
   output logic             idle
);

   // microprogram addresses
   localparam logic [UPC_W-1:0] U_PUSH    = 5'd0;
   localparam logic [UPC_W-1:0] U_PUSH_WR = 5'd1;
   localparam logic [UPC_W-1:0] U_POP     = 5'd2;
   localparam logic [UPC_W-1:0] U_POP_DEC = 5'd3;
   localparam logic [UPC_W-1:0] U_AR      = 5'd4;
   localparam logic [UPC_W-1:0] U_AR_RA   = 5'd5;
   localparam logic [UPC_W-1:0] U_AR_RB   = 5'd6;
   localparam logic [UPC_W-1:0] U_AR_LB   = 5'd7;
   localparam logic [UPC_W-1:0] U_AR_SEL  = 5'd8;
   localparam logic [UPC_W-1:0] U_AR_ALU  = 5'd9;
   localparam logic [UPC_W-1:0] U_AR_WR   = 5'd10;
   localparam logic [UPC_W-1:0] U_DV_CHK  = 5'd11;
   localparam logic [UPC_W-1:0] U_DV_GO   = 5'd12;
   localparam logic [UPC_W-1:0] U_DV_WAIT = 5'd13;
   localparam logic [UPC_W-1:0] U_DV_LD   = 5'd14;
   localparam logic [UPC_W-1:0] U_E_FULL  = 5'd15;
   localparam logic [UPC_W-1:0] U_E_FEW   = 5'd16;
   localparam logic [UPC_W-1:0] U_E_DIVZ  = 5'd17;
   localparam logic [UPC_W-1:0] U_FIN     = 5'd18;
   localparam logic [UPC_W-1:0] U_FIN_OUT = 5'd19;

   typedef enum logic {SQ_IDLE, SQ_RUN} sq_state_type;

   function automatic logic [UPC_W-1:0] entry_of(input logic [CMD_W-1:0] cmd);
      logic [UPC_W-1:0] e;
      unique case (cmd) inside
         CMD_PUSH:                          e = U_PUSH;
         CMD_POP:                           e = U_POP;
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: e = U_AR;
         default:                           e = U_FIN;   // unused codes: no-op
      endcase
      return e;
   endfunction

   function automatic rsa_ctrl_type rom_word(input logic [UPC_W-1:0] upc);
      rsa_ctrl_type w;
      w = '0;
      unique case (upc)
         U_PUSH:    begin w.jc = JC_FULL;   w.target = U_E_FULL; end
         U_PUSH_WR: begin
            w.wr = WR_PUSH; w.cnt_op = CNT_INC; w.jc = JC_ALWAYS; w.target = U_FIN;
         end
         U_POP:     begin w.jc = JC_LT1;    w.target = U_E_FEW; end
         U_POP_DEC: begin w.cnt_op = CNT_DEC; w.jc = JC_ALWAYS; w.target = U_FIN; end
         U_AR:      begin w.jc = JC_LT2;    w.target = U_E_FEW; end
         U_AR_RA:   begin w.rd = RD_TOP; end
         U_AR_RB:   begin w.ld = LD_A; w.rd = RD_NEXT; end
         U_AR_LB:   begin w.ld = LD_B; w.cnt_op = CNT_DEC2; end
         U_AR_SEL:  begin w.jc = JC_DIV;    w.target = U_DV_CHK; end
         U_AR_ALU:  begin w.ld = LD_ALU; end
         U_AR_WR:   begin
            w.wr = WR_RES; w.cnt_op = CNT_INC; w.jc = JC_ALWAYS; w.target = U_FIN;
         end
         U_DV_CHK:  begin w.jc = JC_BZ;     w.target = U_E_DIVZ; end
         U_DV_GO:   begin w.div_start = 1'b1; end
         U_DV_WAIT: begin w.jc = JC_DIVBUSY; w.target = U_DV_WAIT; end
         U_DV_LD:   begin w.ld = LD_DIV; w.jc = JC_ALWAYS; w.target = U_AR_WR; end
         U_E_FULL:  begin
            w.st_set = 1'b1; w.st_code = ST_FULL; w.jc = JC_ALWAYS; w.target = U_FIN;
         end
         U_E_FEW:   begin
            w.st_set = 1'b1; w.st_code = ST_FEW; w.jc = JC_ALWAYS; w.target = U_FIN;
         end
         U_E_DIVZ:  begin
            w.st_set = 1'b1; w.st_code = ST_DIVZ; w.jc = JC_ALWAYS; w.target = U_FIN;
         end
         U_FIN:     begin w.rd = RD_TOP; end
         U_FIN_OUT: begin w.done = 1'b1; end
         default:   begin w.jc = JC_ALWAYS; w.target = U_FIN; end
      endcase
      return w;
   endfunction

   sq_state_type     state_ff;
   logic [UPC_W-1:0] upc_ff;
   rsa_ctrl_type     word;
   logic             take;

   assign word = rom_word(upc_ff);

   always_comb begin
      unique case (word.jc)
         JC_NONE:    take = 1'b0;
         JC_ALWAYS:  take = 1'b1;
         JC_FULL:    take = cond.full;
         JC_LT1:     take = cond.lt1;
         JC_LT2:     take = cond.lt2;
         JC_BZ:      take = cond.bz;
         JC_DIV:     take = cond.is_div;
         JC_DIVBUSY: take = cond.div_busy;
         default:    take = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         upc_ff   <= '0;
      end else begin
         unique case (state_ff)
            SQ_IDLE: begin
               if (start) begin
                  upc_ff   <= entry_of(start_cmd);
                  state_ff <= SQ_RUN;
               end
            end
            SQ_RUN: begin
               if (word.done) begin
                  if (cond.out_free) begin
                     state_ff <= SQ_IDLE;
                  end
               end else if (take) begin
                  upc_ff <= word.target;
               end else begin
                  upc_ff <= upc_ff + 1'b1;
               end
            end
            default: state_ff <= SQ_IDLE;
         endcase
      end
   end

   assign idle = (state_ff == SQ_IDLE);
   assign ctrl = (state_ff == SQ_RUN) ? word : rsa_ctrl_type'('0);

endmodule

// ----- rtl/rpn_stack_alu.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_alu
// Reverse-Polish stack calculator: bounded stack of signed 32-bit operands,
// push / pop / add / subtract / multiply / divide, one result per command.
// ----------------------------------------------------------------------------
// Each command, no-op and error exits included, runs as a microcode
//   sequence; divide also waits on the radix-2 divider.
// One transaction in flight; the next request is taken in the cycle after
//   the result is loaded.
// Reset clears the stack count and control; stack contents are undefined
//   until pushed and get no clearing pass.
module rpn_stack_alu
   import rsa_pkg::*;
#(
   parameter int STACK_DEPTH = RSA_STACK_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_type,
   input  logic signed [DATA_W-1:0] req_push_value,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_top_value,
   output logic [DEPTH_FIELD_W-1:0] rsp_depth
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // ------------------------------------------------------------------
   // Stack storage: one write port, one registered read port.
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_ff;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;

   // control and datapath registers
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] res_ff, res_in;
   rsa_status_type    status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsa_status_type           rsp_status_ff;
   logic [DATA_W-1:0]        rsp_top_ff;
   logic [DEPTH_FIELD_W-1:0] rsp_depth_ff;

   // sequencer interface
   rsa_ctrl_type ctrl;
   rsa_cond_type cond;
   logic         seq_idle;
   logic         req_accept;
   logic         out_free;
   logic         emit;

   // divider
   logic              div_busy;
   logic [DATA_W-1:0] div_quo;

   logic [DATA_W-1:0] alu_out;
   logic [DATA_W-1:0] mul_lo;
   logic [CW-1:0]     cnt_m1;
   logic [CW-1:0]     cnt_m2;
   logic [CW+DEPTH_FIELD_W-1:0] cnt_wide;

   assign req_stall  = !seq_idle;
   assign req_accept = req_valid && !req_stall;

   // output register frees when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = ctrl.done && out_free;

   // ------------------------------------------------------------------
   // Conditions for microcode jumps
   // ------------------------------------------------------------------
   always_comb begin
      cond          = '0;
      cond.full     = (cnt_ff == CW'(STACK_DEPTH));
      cond.lt1      = (cnt_ff == '0);
      cond.lt2      = (cnt_ff < CW'(2));
      cond.bz       = (b_ff == '0);
      cond.is_div   = (cmd_ff == CMD_DIV);
      cond.div_busy = div_busy;
      cond.out_free = out_free;
   end

   rsa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .start_cmd (req_type),
      .cond      (cond),
      .ctrl      (ctrl),
      .idle      (seq_idle)
   );

   // a is the popped top, b the entry below it: quotient is a / b
   rsa_div #(
      .DW (DATA_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // ------------------------------------------------------------------
   // Stack addressing
   // ------------------------------------------------------------------
   assign cnt_m1 = cnt_ff - CW'(1);
   assign cnt_m2 = cnt_ff - CW'(2);
   assign rd_addr = (ctrl.rd == RD_NEXT) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
   // writes only happen below STACK_DEPTH, so the low bits address the slot
   assign wr_addr = cnt_ff[AW-1:0];
   assign wr_data = (ctrl.wr == WR_PUSH) ? val_ff : res_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr != WR_NONE) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd != RD_NONE) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // ALU: wrapping add/sub, low half of the product
   // ------------------------------------------------------------------
   assign mul_lo = a_ff * b_ff;

   always_comb begin
      case (cmd_ff)
         CMD_ADD: alu_out = a_ff + b_ff;
         CMD_SUB: alu_out = a_ff - b_ff;
         CMD_MUL: alu_out = mul_lo;
         default: alu_out = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Next-state logic for datapath registers
   // ------------------------------------------------------------------
   always_comb begin
      cnt_in = cnt_ff;
      case (ctrl.cnt_op)
         CNT_INC:  cnt_in = cnt_ff + CW'(1);
         CNT_DEC:  cnt_in = cnt_m1;
         CNT_DEC2: cnt_in = cnt_m2;
         default:  cnt_in = cnt_ff;
      endcase

      a_in   = a_ff;
      b_in   = b_ff;
      res_in = res_ff;
      case (ctrl.ld)
         LD_A:    a_in   = rd_ff;
         LD_B:    b_in   = rd_ff;
         LD_ALU:  res_in = alu_out;
         LD_DIV:  res_in = div_quo;
         default: res_in = res_ff;
      endcase

      status_in = status_ff;
      if (req_accept) begin
         status_in = ST_OK;
      end else if (ctrl.st_set) begin
         status_in = ctrl.st_code;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cnt_wide = {{DEPTH_FIELD_W{1'b0}}, cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      if (req_accept) begin
         cmd_ff <= req_type;
         val_ff <= req_push_value;
      end
      // result transaction: top reads as zero on an empty stack
      if (emit) begin
         rsp_status_ff <= status_ff;
         rsp_top_ff    <= (cnt_ff == '0) ? '0 : rd_ff;
         rsp_depth_ff  <= cnt_wide[DEPTH_FIELD_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      emit && (status_ff == ST_FULL) |-> cond.full && (cmd_ff == CMD_PUSH))
      else $error("full status without a full stack");

   a_divz_cmd: assert property (@(posedge clock) disable iff (reset)
      emit && (status_ff == ST_DIVZ) |-> (cmd_ff == CMD_DIV))
      else $error("divide-by-zero status on a non-divide");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      ctrl.div_start |=> div_busy)
      else $error("divider did not start");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !seq_idle)
      else $error("divider running while sequencer idle");

endmodule

// ----- bench/rpn_stack_alu_test.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_alu_test
// Self-checking bench for the RPN stack ALU. A shadow stack predicts status,
// new top and depth for every accepted command; a checker compares each
// result transaction in order. Directed tests cover empty-stack errors,
// arithmetic wrap and divide corners, result back-pressure and a full
// stack. Random command mixes with random idles on both channels follow.
// ----------------------------------------------------------------------------
module rpn_stack_alu_test;
   import rsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Codes outside the command set; the block treats them as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
   localparam int MAX_IDLE   = 19;
   localparam int TAIL_WAIT  = 60;   // a bit over the divide latency
   localparam int RANDOM_CMDS = 420;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_type       = '0;
   logic signed [DATA_W-1:0]  req_push_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic [1:0]                rsp_status;
   logic signed [DATA_W-1:0]  rsp_top_value;
   logic [DEPTH_FIELD_W-1:0]  rsp_depth;

   rpn_stack_alu dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_top_value  (rsp_top_value),
      .rsp_depth      (rsp_depth)
   );

   always #1ns clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow stack and the results it predicts
   // ------------------------------------------------------------------
   typedef struct {
      logic [CMD_W-1:0]         cmd;
      rsa_status_type           status;
      logic [DATA_W-1:0]        top_value;
      logic [DEPTH_FIELD_W-1:0] depth;
   } stack_result_type;

   logic [DATA_W-1:0] shadow_stack [RSA_STACK_DEPTH];
   int                shadow_count = 0;
   stack_result_type  pending_results [$];

   int mismatch_count = 0;
   int result_count   = 0;

   // idle controls for the sender and the receiver
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   int long_hold      = 0;   // one-shot request for a long receiver hold-off
   int stall_left     = 0;

   // Apply one accepted command to the shadow stack, queue its result
   function automatic void predict_command(logic [CMD_W-1:0] cmd,
                                           logic [DATA_W-1:0] value);
      rsa_status_type    status;
      logic [DATA_W-1:0] a, b, r, mag_a, mag_b, quot;
      stack_result_type  res;
      status = ST_OK;
      r      = '0;
      case (cmd)
         CMD_PUSH: begin
            if (shadow_count >= RSA_STACK_DEPTH) begin
               status = ST_FULL;
            end else begin
               shadow_stack[shadow_count] = value;
               shadow_count++;
            end
         end
         CMD_POP: begin
            if (shadow_count == 0) status = ST_FEW;
            else shadow_count--;
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            if (shadow_count < 2) begin
               status = ST_FEW;
            end else begin
               // a is the top entry, b the one below it
               a = shadow_stack[shadow_count-1];
               b = shadow_stack[shadow_count-2];
               shadow_count -= 2;
               case (cmd)
                  CMD_ADD: r = a + b;
                  CMD_SUB: r = a - b;
                  CMD_MUL: r = a * b;   // low 32 bits, same for signed
                  default: begin
                     if (b == '0) begin
                        status = ST_DIVZ;
                     end else begin
                        // unsigned magnitudes; min / -1 wraps back to min
                        mag_a = a[DATA_W-1] ? -a : a;
                        mag_b = b[DATA_W-1] ? -b : b;
                        quot  = mag_a / mag_b;
                        r     = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quot : quot;
                     end
                  end
               endcase
               if (status == ST_OK) begin
                  shadow_stack[shadow_count] = r;
                  shadow_count++;
               end
            end
         end
         default: ;   // spare codes: no-op, status ok
      endcase
      res.cmd       = cmd;
      res.status    = status;
      res.top_value = (shadow_count == 0) ? '0 : shadow_stack[shadow_count-1];
      res.depth     = shadow_count[DEPTH_FIELD_W-1:0];
      pending_results.push_back(res);
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t ns mismatch: %s", $realtime, what);
   endtask

   // ------------------------------------------------------------------
   // Result channel: receiver stall pattern and checker
   // ------------------------------------------------------------------
   // After each result transaction draw a new hold-off; a long hold
   // request from a test overrides it and is counted down here.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
         stall_left = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (long_hold > 0) begin
         stall_left = long_hold;
         long_hold  = 0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Values sampled here are the ones present at the edge
   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         result_count++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d with no command outstanding",
                                      result_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d cmd %0d status %0d, want %0d",
                  result_count, want.cmd, rsp_status, want.status));
            if (rsp_top_value !== want.top_value)
               report_mismatch($sformatf("result %0d cmd %0d top %h, want %h",
                  result_count, want.cmd, rsp_top_value, want.top_value));
            if (rsp_depth !== want.depth)
               report_mismatch($sformatf("result %0d cmd %0d depth %0d, want %0d",
                  result_count, want.cmd, rsp_depth, want.depth));
         end
      end
   end

   // ------------------------------------------------------------------
   // Request channel
   // ------------------------------------------------------------------
   // Valid stays high after a transaction so a back-to-back command needs
   // only one assignment in that step; idle gaps and result waits drop it.
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= cmd;
      req_push_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_command(cmd, value);
   endtask

   // Stop offering commands until every predicted result is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3, 4:    return $urandom_range(0, 16) - 8;   // small, zero included
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_arith();
      case ($urandom_range(0, 3))
         0:       return CMD_ADD;
         1:       return CMD_SUB;
         2:       return CMD_MUL;
         default: return CMD_DIV;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Every command on an empty stack, then binary ops with one entry
   task automatic test_empty_stack();
      send_command(CMD_POP, $urandom());
      send_command(CMD_ADD, $urandom());
      send_command(CMD_SUB, $urandom());
      send_command(CMD_MUL, $urandom());
      send_command(CMD_DIV, $urandom());
      send_command(CMD_SPARE6, $urandom());
      send_command(CMD_SPARE7, $urandom());
      send_command(CMD_PUSH, 32'd42);
      send_command(CMD_ADD, $urandom());
      send_command(CMD_DIV, $urandom());
      send_command(CMD_SPARE6, $urandom());
      send_command(CMD_POP, $urandom());
   endtask

   // Wrap on add, sub and mul; divide truncation, min / -1, divide by zero
   task automatic test_arith_corners();
      send_command(CMD_PUSH, 32'd1);
      send_command(CMD_PUSH, 32'h7FFF_FFFF);
      send_command(CMD_ADD,  $urandom());       // max + 1 -> min
      send_command(CMD_PUSH, 32'd1);
      send_command(CMD_SUB,  $urandom());       // 1 - min
      send_command(CMD_PUSH, 32'hFFFF_FFFF);
      send_command(CMD_PUSH, 32'h8000_0000);
      send_command(CMD_DIV,  $urandom());       // min / -1 wraps
      send_command(CMD_PUSH, 32'h7FFF_FFFF);
      send_command(CMD_PUSH, 32'h7FFF_FFFF);
      send_command(CMD_MUL,  $urandom());
      send_command(CMD_PUSH, 32'd0);
      send_command(CMD_PUSH, 32'd5);
      send_command(CMD_DIV,  $urandom());       // b is zero: both consumed
      send_command(CMD_PUSH, 32'd2);
      send_command(CMD_PUSH, -7);
      send_command(CMD_DIV,  $urandom());       // -3, toward zero
      send_command(CMD_PUSH, 32'h5555_5555);
      send_command(CMD_PUSH, 32'hAAAA_AAAA);
      send_command(CMD_SUB,  $urandom());
      send_command(CMD_PUSH, -2);
      send_command(CMD_PUSH, 32'd7);
      send_command(CMD_DIV,  $urandom());
      send_command(CMD_SPARE7, $urandom());
   endtask

   // Receiver holds off for a long stretch while the sender keeps going,
   // so the block backs up and stalls its request side.
   task automatic test_result_backpressure();
      wait_for_results();
      sender_idles = 1'b0;
      long_hold    = 300;
      repeat (10) send_command(CMD_PUSH, pick_operand());
      repeat (8) send_command(pick_arith(), $urandom());
      sender_idles = 1'b1;
      wait_for_results();
   endtask

   // Fill to the limit, push into a full stack, then reduce a little;
   // the random mix that follows works the deep stack back down.
   task automatic test_full_stack();
      while (shadow_count < RSA_STACK_DEPTH)
         send_command(CMD_PUSH, pick_operand());
      send_command(CMD_PUSH, $urandom());
      send_command(CMD_PUSH, $urandom());
      send_command(CMD_SPARE6, $urandom());
      repeat (24) send_command(pick_arith(), $urandom());
      send_command(CMD_POP, $urandom());
   endtask

   // Mixed command streams starting from the deep stack left behind, with
   // some noise. A stretch without idles and a full pause in the middle.
   task automatic test_random_commands();
      int roll;
      logic [CMD_W-1:0] cmd;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n == 140) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         if (n == 200) begin
            sender_idles   = 1'b1;
            receiver_idles = 1'b1;
         end
         if (n == 280) wait_for_results();
         roll = $urandom_range(0, 99);
         if (roll < 8)
            cmd = CMD_W'($urandom_range(0, 2**CMD_W - 1));
         else if (shadow_count < 2 || (roll < 50 && shadow_count < 40))
            cmd = CMD_PUSH;
         else if (roll < 60)
            cmd = CMD_POP;
         else
            cmd = pick_arith();
         send_command(cmd, (cmd == CMD_PUSH) ? pick_operand() : $urandom());
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_stack();
      test_arith_corners();
      test_result_backpressure();
      test_full_stack();
      test_random_commands();
      wait_for_results();
      repeat (TAIL_WAIT) @(posedge clock);   // catch any stray result
      if (mismatch_count == 0)
         $display("rpn_stack_alu_test: clean");
      else
         $display("rpn_stack_alu_test: errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("rpn_stack_alu_test: errors");
      $finish;
   end

endmodule
